>>> rtl/pga_pkg.sv
package pga_pkg;

    // Fixed field widths
    localparam int CNT_W     = 32;
    localparam int SUM_W     = 48;
    localparam int DEP_W     = 16;
    localparam int LAYER_W   = 5;
    localparam int ROW_W     = 8;
    localparam int PIDX_W    = 13;
    localparam int PAD_W     = 14;
    localparam int HW_LAYERS = 32;

    // Default sizes
    localparam int NUM_PADS_DEF   = 5768;
    localparam int NUM_LAYERS_DEF = 32;

    // Function codes
    localparam logic [1:0] FUNC_EVENT      = 2'd0;
    localparam logic [1:0] FUNC_CLUSTER    = 2'd1;
    localparam logic [1:0] FUNC_READ_PAD   = 2'd2;
    localparam logic [1:0] FUNC_READ_LAYER = 2'd3;

    // One pad entry of the pad memory
    typedef struct packed {
        logic             noisy;
        logic [CNT_W-1:0] hits;
        logic [SUM_W-1:0] sum;
    } t_pad_rec;

    // Item context handed to the update logic
    typedef struct packed {
        logic [1:0]       func;
        logic             has_track;
        logic             pad_ok;
        logic             layer_ok;
        logic             event_open;
        logic [CNT_W-1:0] track_events;
        logic [DEP_W-1:0] deposit;
    } t_upd_in;

    // Write-back and result from the update logic
    typedef struct packed {
        logic             pad_we;
        t_pad_rec         pad_wdata;
        logic             layer_we;
        logic [CNT_W-1:0] layer_wdata;
        logic             event_we;
        logic             event_open;
        logic [CNT_W-1:0] track_events;
        logic             done;
        logic [CNT_W-1:0] count_value;
        logic [SUM_W-1:0] sum_value;
    } t_upd_out;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
        return r;
    endfunction

    // First pad of each layer
    function automatic logic [PIDX_W-1:0] layer_start(input logic [LAYER_W-1:0] layer);
        logic [PIDX_W-1:0] s;
        case (layer)
            5'd0:    s = 13'd0;
            5'd1:    s = 13'd48;
            5'd2:    s = 13'd96;
            5'd3:    s = 13'd168;
            5'd4:    s = 13'd264;
            5'd5:    s = 13'd384;
            5'd6:    s = 13'd528;
            5'd7:    s = 13'd696;
            5'd8:    s = 13'd888;
            5'd9:    s = 13'd1104;
            5'd10:   s = 13'd1344;
            5'd11:   s = 13'd1552;
            5'd12:   s = 13'd1770;
            5'd13:   s = 13'd2000;
            5'd14:   s = 13'd2214;
            5'd15:   s = 13'd2426;
            5'd16:   s = 13'd2640;
            5'd17:   s = 13'd2860;
            5'd18:   s = 13'd3084;
            5'd19:   s = 13'd3316;
            5'd20:   s = 13'd3554;
            5'd21:   s = 13'd3798;
            5'd22:   s = 13'd4030;
            5'd23:   s = 13'd4248;
            5'd24:   s = 13'd4458;
            5'd25:   s = 13'd4664;
            5'd26:   s = 13'd4866;
            5'd27:   s = 13'd5066;
            5'd28:   s = 13'd5262;
            5'd29:   s = 13'd5440;
            5'd30:   s = 13'd5570;
            default: s = 13'd5678;
        endcase
        return s;
    endfunction

    // Fixed noisy-pad mask
    function automatic logic is_noisy(input logic [PAD_W-1:0] pad);
        logic n;
        case (pad) inside
            14'd59, 14'd72, 14'd110, [14'd134:14'd135], 14'd185, 14'd222, 14'd284,
            14'd332, 14'd408, 14'd467, 14'd555, 14'd626, 14'd726, 14'd809, 14'd921,
            14'd1016, 14'd1140, 14'd1363, [14'd1503:14'd1515], [14'd1564:14'd1565],
            [14'd1628:14'd1630], [14'd1728:14'd1730], 14'd1778, [14'd1817:14'd1820],
            [14'd1849:14'd1851], [14'd2035:14'd2038], [14'd2067:14'd2069],
            [14'd2244:14'd2248], [14'd2276:14'd2278], [14'd2454:14'd2457],
            [14'd2485:14'd2488], [14'd2667:14'd2670], [14'd2698:14'd2701],
            [14'd2794:14'd2809], [14'd2886:14'd2888], [14'd2917:14'd2919],
            [14'd3001:14'd3018], [14'd3037:14'd3054], [14'd3110:14'd3113],
            [14'd3141:14'd3143], [14'd3227:14'd3231], [14'd3289:14'd3297],
            [14'd3341:14'd3344], [14'd3373:14'd3375], [14'd3413:14'd3419],
            [14'd3540:14'd3546], [14'd3578:14'd3581], [14'd3610:14'd3612],
            [14'd3660:14'd3665], [14'd3813:14'd3815], [14'd3844:14'd3846],
            [14'd3904:14'd3908], [14'd4034:14'd4036], [14'd4065:14'd4067],
            [14'd4134:14'd4137], [14'd4276:14'd4278], [14'd4353:14'd4356],
            [14'd4409:14'd4452], [14'd4480:14'd4482], [14'd4565:14'd4568],
            [14'd4611:14'd4619], [14'd4680:14'd4682], [14'd4720:14'd4728],
            [14'd4774:14'd4776], [14'd4878:14'd4880], [14'd4929:14'd4936],
            [14'd4981:14'd4982], [14'd5072:14'd5074], [14'd5134:14'd5140],
            [14'd5183:14'd5184], [14'd5328:14'd5333], [14'd5372:14'd5374],
            [14'd5487:14'd5492], [14'd5530:14'd5533], [14'd5612:14'd5616],
            [14'd5654:14'd5655], [14'd5716:14'd5720], [14'd5757:14'd5758]: n = 1'b1;
            default: n = 1'b0;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/pga_ram.sv
module pga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pga_upd.sv
module pga_upd (
    input  pga_pkg::t_upd_in                i_ctx,
    input  pga_pkg::t_pad_rec               i_pad_rd,
    input  logic [pga_pkg::CNT_W-1:0]       i_layer_rd,
    output pga_pkg::t_upd_out               o_upd
);

    logic [pga_pkg::SUM_W:0]   sum_full;
    logic [pga_pkg::SUM_W-1:0] sum_sat;
    logic                      pad_noisy;

    // Saturating deposit sum
    assign sum_full  = {1'b0, i_pad_rd.sum} + (pga_pkg::SUM_W+1)'(i_ctx.deposit);
    assign sum_sat   = sum_full[pga_pkg::SUM_W] ? {pga_pkg::SUM_W{1'b1}}
                                                : sum_full[pga_pkg::SUM_W-1:0];
    assign pad_noisy = i_ctx.pad_ok && i_pad_rd.noisy;

    // Decode the function and build write-back and result
    always_comb begin
        o_upd              = '0;
        o_upd.event_open   = i_ctx.event_open;
        o_upd.track_events = i_ctx.track_events;
        unique case (i_ctx.func)
            pga_pkg::FUNC_EVENT: begin
                o_upd.event_we   = 1'b1;
                o_upd.event_open = i_ctx.has_track;
                if (i_ctx.has_track) begin
                    o_upd.track_events = pga_pkg::sat_inc(i_ctx.track_events);
                end
            end
            pga_pkg::FUNC_CLUSTER: begin
                if (i_ctx.event_open && i_ctx.layer_ok && !pad_noisy) begin
                    o_upd.layer_we    = 1'b1;
                    o_upd.layer_wdata = pga_pkg::sat_inc(i_layer_rd);
                    if (i_ctx.pad_ok) begin
                        o_upd.pad_we          = 1'b1;
                        o_upd.pad_wdata.noisy = i_pad_rd.noisy;
                        o_upd.pad_wdata.hits  = pga_pkg::sat_inc(i_pad_rd.hits);
                        o_upd.pad_wdata.sum   = sum_sat;
                    end
                end
            end
            pga_pkg::FUNC_READ_PAD: begin
                o_upd.done = 1'b1;
                if (i_ctx.pad_ok) begin
                    o_upd.count_value = i_pad_rd.hits;
                    o_upd.sum_value   = i_pad_rd.sum;
                end
            end
            pga_pkg::FUNC_READ_LAYER: begin
                o_upd.done        = 1'b1;
                o_upd.count_value = i_ctx.layer_ok ? i_layer_rd : '0;
                o_upd.sum_value   = pga_pkg::SUM_W'(i_ctx.track_events);
            end
            default: begin
                o_upd.done = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/pad_gain_accumulator.sv
// Per-pad gain accumulator.
// Command channel: drive the item fields with start high; the word is taken
// at a rising edge where start is high and busy is low. Function codes:
// event start, cluster, read pad, read layer. Only the two reads return a
// word: o_done pulses for one cycle with o_count_value / o_sum_value, and the
// receiver must take it then (there is no back-pressure).
// Flow: an accepted item goes to S_READ, where its memory entries are read
// into the RAM output registers, then to S_UPDATE, where the write-back and
// any result are applied at the edge that closes S_UPDATE. A new word can be
// taken in S_UPDATE but not in S_READ, so a new item waits until the last
// one has reached its write-back, as the pad memory is read and registered
// ahead of its write-back; read and write of one entry never overlap.
// Reset (synchronous, active low) starts a pass over all NUM_PADS addresses
// that zeroes the pad and layer memories and loads each pad's noisy flag;
// busy stays high for the whole pass. Event state and total reset at once.
module pad_gain_accumulator #(
    parameter int NUM_PADS   = pga_pkg::NUM_PADS_DEF,
    parameter int NUM_LAYERS = pga_pkg::NUM_LAYERS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_func,
    input  logic                          i_has_track,
    input  logic [pga_pkg::LAYER_W-1:0]   i_layer,
    input  logic [pga_pkg::ROW_W-1:0]     i_row,
    input  logic                          i_row_invalid,
    input  logic [pga_pkg::DEP_W-1:0]     i_deposit,
    input  logic [pga_pkg::PIDX_W-1:0]    i_pad_index,
    output logic                          o_done,
    output logic [pga_pkg::CNT_W-1:0]     o_count_value,
    output logic [pga_pkg::SUM_W-1:0]     o_sum_value
);

    localparam int PAW         = $clog2(NUM_PADS);
    localparam int LAYER_DEPTH = (NUM_LAYERS < pga_pkg::HW_LAYERS) ? NUM_LAYERS
                                                                   : pga_pkg::HW_LAYERS;
    localparam int LAW         = (LAYER_DEPTH > 1) ? $clog2(LAYER_DEPTH) : 1;
    localparam int PAD_RW      = $bits(pga_pkg::t_pad_rec);

    localparam logic [pga_pkg::PAD_W:0] NUM_PADS_L    = (pga_pkg::PAD_W+1)'(NUM_PADS);
    localparam logic [6:0]              NUM_LAYERS_L  = 7'(NUM_LAYERS);
    localparam logic [PAW:0]            LAYER_DEPTH_L = (PAW+1)'(LAYER_DEPTH);
    localparam logic [PAW-1:0]          LAST_PAD      = PAW'(NUM_PADS - 1);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [PAW-1:0]               r_clr_cnt;
    logic                         accept;

    logic [1:0]                   r_func;
    logic                         r_has_track;
    logic [pga_pkg::LAYER_W-1:0]  r_layer;
    logic [pga_pkg::DEP_W-1:0]    r_deposit;
    logic [pga_pkg::PAD_W-1:0]    r_pad;
    logic                         r_pad_ok;
    logic                         r_layer_ok;
    logic                         r_event_open;
    logic [pga_pkg::CNT_W-1:0]    r_track_events;

    logic [pga_pkg::PAD_W-1:0]    n_pad;
    logic                         n_pad_ok;
    logic                         n_layer_ok;

    logic                         r_done;
    logic [pga_pkg::CNT_W-1:0]    r_count_value;
    logic [pga_pkg::SUM_W-1:0]    r_sum_value;

    logic                         pad_we;
    logic [PAW-1:0]               pad_waddr;
    pga_pkg::t_pad_rec            pad_wdata;
    logic [PAD_RW-1:0]            pad_rdata;
    logic                         layer_we;
    logic [LAW-1:0]               layer_addr;
    logic [LAW-1:0]               layer_waddr;
    logic [pga_pkg::CNT_W-1:0]    layer_wdata;
    logic [pga_pkg::CNT_W-1:0]    layer_rdata;

    pga_pkg::t_upd_in             upd_ctx;
    pga_pkg::t_upd_out            upd;

    assign busy   = (r_state == S_CLEAR) || (r_state == S_READ);
    assign accept = start && !busy;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == LAST_PAD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = accept ? S_READ : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + PAW'(1);
            end
        end
    end

    // Form the pad id and range flags of an incoming word
    always_comb begin
        if (i_func == pga_pkg::FUNC_READ_PAD) begin
            n_pad = pga_pkg::PAD_W'(i_pad_index);
        end else begin
            n_pad = pga_pkg::PAD_W'(pga_pkg::layer_start(i_layer))
                  + pga_pkg::PAD_W'(i_row);
        end
        n_pad_ok   = ({1'b0, n_pad} < NUM_PADS_L)
                   && !((i_func == pga_pkg::FUNC_CLUSTER) && i_row_invalid);
        n_layer_ok = (7'(i_layer) < NUM_LAYERS_L);
    end

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func      <= i_func;
            r_has_track <= i_has_track;
            r_layer     <= i_layer;
            r_deposit   <= i_deposit;
            r_pad       <= n_pad;
            r_pad_ok    <= n_pad_ok;
            r_layer_ok  <= n_layer_ok;
        end
    end

    // Memory addressing: clearing pass or item access
    assign layer_addr = r_layer_ok ? r_layer[LAW-1:0] : '0;

    always_comb begin
        if (r_state == S_CLEAR) begin
            pad_we          = 1'b1;
            pad_waddr       = r_clr_cnt;
            pad_wdata       = '0;
            pad_wdata.noisy = pga_pkg::is_noisy(pga_pkg::PAD_W'(r_clr_cnt));
            layer_we        = ({1'b0, r_clr_cnt} < LAYER_DEPTH_L);
            layer_waddr     = r_clr_cnt[LAW-1:0];
            layer_wdata     = '0;
        end else begin
            pad_we          = (r_state == S_UPDATE) && upd.pad_we;
            pad_waddr       = r_pad[PAW-1:0];
            pad_wdata       = upd.pad_wdata;
            layer_we        = (r_state == S_UPDATE) && upd.layer_we;
            layer_waddr     = layer_addr;
            layer_wdata     = upd.layer_wdata;
        end
    end

    pga_ram #(
        .WIDTH (PAD_RW),
        .DEPTH (NUM_PADS)
    ) u_pad_ram (
        .i_clk   (i_clk),
        .i_we    (pad_we),
        .i_waddr (pad_waddr),
        .i_wdata (pad_wdata),
        .i_raddr (r_pad[PAW-1:0]),
        .o_rdata (pad_rdata)
    );

    pga_ram #(
        .WIDTH (pga_pkg::CNT_W),
        .DEPTH (LAYER_DEPTH)
    ) u_layer_ram (
        .i_clk   (i_clk),
        .i_we    (layer_we),
        .i_waddr (layer_waddr),
        .i_wdata (layer_wdata),
        .i_raddr (layer_addr),
        .o_rdata (layer_rdata)
    );

    // Modify step
    always_comb begin
        upd_ctx.func         = r_func;
        upd_ctx.has_track    = r_has_track;
        upd_ctx.pad_ok       = r_pad_ok;
        upd_ctx.layer_ok     = r_layer_ok;
        upd_ctx.event_open   = r_event_open;
        upd_ctx.track_events = r_track_events;
        upd_ctx.deposit      = r_deposit;
    end

    pga_upd u_upd (
        .i_ctx      (upd_ctx),
        .i_pad_rd   (pga_pkg::t_pad_rec'(pad_rdata)),
        .i_layer_rd (layer_rdata),
        .o_upd      (upd)
    );

    // Event state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_open   <= 1'b0;
            r_track_events <= '0;
        end else if ((r_state == S_UPDATE) && upd.event_we) begin
            r_event_open   <= upd.event_open;
            r_track_events <= upd.track_events;
        end
    end

    // Result word, one cycle wide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == S_UPDATE) && upd.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_count_value <= upd.count_value;
            r_sum_value   <= upd.sum_value;
        end
    end

    assign o_done        = r_done;
    assign o_count_value = r_count_value;
    assign o_sum_value   = r_sum_value;

endmodule

>>> bench/tb_top.sv
module tb_top;

    localparam int NUM_PADS     = pga_pkg::NUM_PADS_DEF;
    localparam int NUM_LAYERS   = pga_pkg::NUM_LAYERS_DEF;
    localparam int READ_LATENCY = 2;
    localparam int RUN_LIMIT    = 250000 * 8;
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        logic [pga_pkg::CNT_W-1:0] count;
        logic [pga_pkg::SUM_W-1:0] sum;
    } t_readout;

    // Block ports
    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         start         = 1'b0;
    logic                         busy;
    logic [1:0]                   i_func        = pga_pkg::FUNC_EVENT;
    logic                         i_has_track   = 1'b0;
    logic [pga_pkg::LAYER_W-1:0]  i_layer       = '0;
    logic [pga_pkg::ROW_W-1:0]    i_row         = '0;
    logic                         i_row_invalid = 1'b0;
    logic [pga_pkg::DEP_W-1:0]    i_deposit     = '0;
    logic [pga_pkg::PIDX_W-1:0]   i_pad_index   = '0;
    logic                         o_done;
    logic [pga_pkg::CNT_W-1:0]    o_count_value;
    logic [pga_pkg::SUM_W-1:0]    o_sum_value;

    // Mirror of the detector stores
    logic [pga_pkg::CNT_W-1:0]    pad_hit_cnt [NUM_PADS];
    logic [pga_pkg::SUM_W-1:0]    pad_dep_sum [NUM_PADS];
    bit                           pad_noisy   [NUM_PADS];
    logic [pga_pkg::CNT_W-1:0]    layer_hit_cnt [pga_pkg::HW_LAYERS];
    logic [pga_pkg::PAD_W-1:0]    first_pad   [pga_pkg::HW_LAYERS];
    logic [pga_pkg::CNT_W-1:0]    track_total;
    bit                           in_track_event;
    int pads_per_layer [pga_pkg::HW_LAYERS] = '{
        48, 48, 72, 96, 120, 144, 168, 192, 216, 240, 208, 218, 230, 214, 212, 214,
        220, 224, 232, 238, 244, 232, 218, 210, 206, 202, 200, 196, 178, 130, 108, 90
    };

    t_readout readout_q [$];
    int       idle_pct      = 0;
    int       words_sent    = 0;
    int       words_counted = 0;
    int       reads_checked = 0;
    int       mismatches    = 0;

    pad_gain_accumulator #(
        .NUM_PADS   (NUM_PADS),
        .NUM_LAYERS (NUM_LAYERS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_has_track   (i_has_track),
        .i_layer       (i_layer),
        .i_row         (i_row),
        .i_row_invalid (i_row_invalid),
        .i_deposit     (i_deposit),
        .i_pad_index   (i_pad_index),
        .o_done        (o_done),
        .o_count_value (o_count_value),
        .o_sum_value   (o_sum_value)
    );

    always #4 i_clk = ~i_clk;

    task automatic mark_noisy(input int lo, input int hi);
        for (int p = lo; p <= hi; p++) pad_noisy[p] = 1'b1;
    endtask

    // Load the fixed tables and clear the mirrored stores
    task automatic init_mirror();
        int acc;
        acc = 0;
        for (int l = 0; l < pga_pkg::HW_LAYERS; l++) begin
            first_pad[l]     = pga_pkg::PAD_W'(acc);
            acc             += pads_per_layer[l];
            layer_hit_cnt[l] = '0;
        end
        for (int p = 0; p < NUM_PADS; p++) begin
            pad_hit_cnt[p] = '0;
            pad_dep_sum[p] = '0;
            pad_noisy[p]   = 1'b0;
        end
        track_total    = '0;
        in_track_event = 1'b0;
        mark_noisy(59, 59);     mark_noisy(72, 72);     mark_noisy(110, 110);
        mark_noisy(134, 135);   mark_noisy(185, 185);   mark_noisy(222, 222);
        mark_noisy(284, 284);   mark_noisy(332, 332);   mark_noisy(408, 408);
        mark_noisy(467, 467);   mark_noisy(555, 555);   mark_noisy(626, 626);
        mark_noisy(726, 726);   mark_noisy(809, 809);   mark_noisy(921, 921);
        mark_noisy(1016, 1016); mark_noisy(1140, 1140); mark_noisy(1363, 1363);
        mark_noisy(1503, 1515); mark_noisy(1564, 1565); mark_noisy(1628, 1630);
        mark_noisy(1728, 1730); mark_noisy(1778, 1778); mark_noisy(1817, 1820);
        mark_noisy(1849, 1851); mark_noisy(2035, 2038); mark_noisy(2067, 2069);
        mark_noisy(2244, 2248); mark_noisy(2276, 2278); mark_noisy(2454, 2457);
        mark_noisy(2485, 2488); mark_noisy(2667, 2670); mark_noisy(2698, 2701);
        mark_noisy(2794, 2809); mark_noisy(2886, 2888); mark_noisy(2917, 2919);
        mark_noisy(3001, 3018); mark_noisy(3037, 3054); mark_noisy(3110, 3113);
        mark_noisy(3141, 3143); mark_noisy(3227, 3231); mark_noisy(3289, 3297);
        mark_noisy(3341, 3344); mark_noisy(3373, 3375); mark_noisy(3413, 3419);
        mark_noisy(3540, 3546); mark_noisy(3578, 3581); mark_noisy(3610, 3612);
        mark_noisy(3660, 3665); mark_noisy(3813, 3815); mark_noisy(3844, 3846);
        mark_noisy(3904, 3908); mark_noisy(4034, 4036); mark_noisy(4065, 4067);
        mark_noisy(4134, 4137); mark_noisy(4276, 4278); mark_noisy(4353, 4356);
        mark_noisy(4409, 4452); mark_noisy(4480, 4482); mark_noisy(4565, 4568);
        mark_noisy(4611, 4619); mark_noisy(4680, 4682); mark_noisy(4720, 4728);
        mark_noisy(4774, 4776); mark_noisy(4878, 4880); mark_noisy(4929, 4936);
        mark_noisy(4981, 4982); mark_noisy(5072, 5074); mark_noisy(5134, 5140);
        mark_noisy(5183, 5184); mark_noisy(5328, 5333); mark_noisy(5372, 5374);
        mark_noisy(5487, 5492); mark_noisy(5530, 5533); mark_noisy(5612, 5616);
        mark_noisy(5654, 5655); mark_noisy(5716, 5720); mark_noisy(5757, 5758);
    endtask

    function automatic logic [pga_pkg::CNT_W-1:0] count_up(
        input logic [pga_pkg::CNT_W-1:0] v
    );
        return (v == {pga_pkg::CNT_W{1'b1}}) ? v : v + pga_pkg::CNT_W'(1);
    endfunction

    // Apply one accepted word to the mirror; queue the readout of a read.
    // Return 1 when the word had any effect.
    function automatic bit accumulate_word(
        input logic [1:0]                  f,
        input logic                        trk,
        input logic [pga_pkg::LAYER_W-1:0] lyr,
        input logic [pga_pkg::ROW_W-1:0]   rw,
        input logic                        rinv,
        input logic [pga_pkg::DEP_W-1:0]   dep,
        input logic [pga_pkg::PIDX_W-1:0]  pidx
    );
        logic [pga_pkg::PAD_W-1:0]  pad;
        logic [pga_pkg::PIDX_W-1:0] pix;
        logic [pga_pkg::SUM_W:0]    wide_sum;
        bit                         pad_ok;
        t_readout                   rd;
        case (f)
            pga_pkg::FUNC_EVENT: begin
                in_track_event = trk;
                if (trk) track_total = count_up(track_total);
                return 1'b1;
            end
            pga_pkg::FUNC_CLUSTER: begin
                if (!in_track_event || int'(lyr) >= NUM_LAYERS) return 1'b0;
                pad    = first_pad[lyr] + pga_pkg::PAD_W'(rw);
                pix    = pad[pga_pkg::PIDX_W-1:0];
                pad_ok = !rinv && int'(pad) < NUM_PADS;
                // drop clusters on masked pads
                if (pad_ok && pad_noisy[pix]) return 1'b0;
                layer_hit_cnt[lyr] = count_up(layer_hit_cnt[lyr]);
                if (pad_ok) begin
                    pad_hit_cnt[pix] = count_up(pad_hit_cnt[pix]);
                    wide_sum = {1'b0, pad_dep_sum[pix]} + (pga_pkg::SUM_W+1)'(dep);
                    pad_dep_sum[pix] = wide_sum[pga_pkg::SUM_W] ? {pga_pkg::SUM_W{1'b1}}
                                                                : wide_sum[pga_pkg::SUM_W-1:0];
                end
                return 1'b1;
            end
            pga_pkg::FUNC_READ_PAD: begin
                if (int'(pidx) < NUM_PADS) begin
                    rd.count = pad_hit_cnt[pidx];
                    rd.sum   = pad_dep_sum[pidx];
                end else begin
                    rd = '0;
                end
                readout_q.push_back(rd);
                return 1'b1;
            end
            default: begin
                rd.count = (int'(lyr) < NUM_LAYERS) ? layer_hit_cnt[lyr] : '0;
                rd.sum   = pga_pkg::SUM_W'(track_total);
                readout_q.push_back(rd);
                return 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    endtask

    // Send one word: idle at random, then hold start until busy is low
    task automatic send_word(
        input logic [1:0]                  f,
        input logic                        trk,
        input logic [pga_pkg::LAYER_W-1:0] lyr,
        input logic [pga_pkg::ROW_W-1:0]   rw,
        input logic                        rinv,
        input logic [pga_pkg::DEP_W-1:0]   dep,
        input logic [pga_pkg::PIDX_W-1:0]  pidx
    );
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_func        <= f;
        i_has_track   <= trk;
        i_layer       <= lyr;
        i_row         <= rw;
        i_row_invalid <= rinv;
        i_deposit     <= dep;
        i_pad_index   <= pidx;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        words_sent++;
        if (accumulate_word(f, trk, lyr, rw, rinv, dep, pidx)) words_counted++;
    endtask

    // Read a pad or a layer, mostly where clusters tend to land
    task automatic send_random_read();
        logic [pga_pkg::LAYER_W-1:0] lyr;
        logic [pga_pkg::PIDX_W-1:0]  pidx;
        int                          pick;
        lyr  = pga_pkg::LAYER_W'($urandom_range(pga_pkg::HW_LAYERS - 1));
        pick = $urandom_range(99);
        if (pick < 70)
            pidx = pga_pkg::PIDX_W'(first_pad[lyr] + pga_pkg::PAD_W'($urandom_range(7)));
        else if (pick < 90)
            pidx = pga_pkg::PIDX_W'($urandom_range(NUM_PADS - 1));
        else
            pidx = pga_pkg::PIDX_W'($urandom_range((1 << pga_pkg::PIDX_W) - 1));
        if ($urandom_range(1))
            send_word(pga_pkg::FUNC_READ_PAD, 1'($urandom_range(1)), lyr,
                      pga_pkg::ROW_W'($urandom), 1'($urandom_range(1)),
                      pga_pkg::DEP_W'($urandom), pidx);
        else
            send_word(pga_pkg::FUNC_READ_LAYER, 1'($urandom_range(1)), lyr,
                      pga_pkg::ROW_W'($urandom), 1'($urandom_range(1)),
                      pga_pkg::DEP_W'($urandom), pidx);
    endtask

    // Compare each result word with the oldest pending readout
    always @(posedge i_clk) begin : check_words
        t_readout want;
        if (o_done === 1'b1) begin
            if (readout_q.size() == 0) begin
                report_mismatch("word with no read pending", 64'(o_count_value), 64'(0));
            end else begin
                want = readout_q.pop_front();
                reads_checked++;
                if (o_count_value !== want.count)
                    report_mismatch("count_value", 64'(o_count_value), 64'(want.count));
                if (o_sum_value !== want.sum)
                    report_mismatch("sum_value", 64'(o_sum_value), 64'(want.sum));
            end
        end
    end

    // Fresh stores read back as zero, out-of-range pad reads give zero
    task automatic test_cleared_readback();
        send_word(pga_pkg::FUNC_READ_PAD, 1'b0, '0, '0, 1'b0, '0, '0);
        send_word(pga_pkg::FUNC_READ_PAD, 1'b0, '0, '0, 1'b0, '0, {pga_pkg::PIDX_W{1'b1}});
        send_word(pga_pkg::FUNC_READ_LAYER, 1'b0, {pga_pkg::LAYER_W{1'b1}}, '0, 1'b0, '0, '0);
        // cluster before any event is ignored
        send_word(pga_pkg::FUNC_CLUSTER, 1'b0, '0, '0, 1'b0, {pga_pkg::DEP_W{1'b1}}, '0);
        send_word(pga_pkg::FUNC_READ_PAD, 1'b0, '0, '0, 1'b0, '0, '0);
    endtask

    // Clusters of a track event: edges, invalid row, overflow past last pad,
    // masked pad and a row running into the next layer
    task automatic test_cluster_cases();
        send_word(pga_pkg::FUNC_EVENT, 1'b1, '0, '0, 1'b0, '0, '0);
        send_word(pga_pkg::FUNC_CLUSTER, 1'b0, '0, '0, 1'b0, {pga_pkg::DEP_W{1'b1}}, '0);
        send_word(pga_pkg::FUNC_CLUSTER, 1'b1, '0, '0, 1'b0, 16'h0001,
                  {pga_pkg::PIDX_W{1'b1}});
        send_word(pga_pkg::FUNC_CLUSTER, 1'b0, 5'd31, 8'd255, 1'b0, 16'h1234, '0);
        send_word(pga_pkg::FUNC_CLUSTER, 1'b0, 5'd31, 8'd89, 1'b0, 16'h0010, '0);
        send_word(pga_pkg::FUNC_CLUSTER, 1'b0, 5'd5, 8'hFF, 1'b1, 16'hABCD, '0);
        send_word(pga_pkg::FUNC_CLUSTER, 1'b0, 5'd10, 8'd159, 1'b0, 16'h0777, '0);
        send_word(pga_pkg::FUNC_CLUSTER, 1'b0, '0, 8'd100, 1'b0, '0, '0);
        send_word(pga_pkg::FUNC_READ_PAD, 1'b0, '0, '0, 1'b0, '0, '0);
        send_word(pga_pkg::FUNC_READ_PAD, 1'b0, '0, '0, 1'b0, '0, 13'd5767);
        send_word(pga_pkg::FUNC_READ_PAD, 1'b0, '0, '0, 1'b0, '0, 13'd1503);
        send_word(pga_pkg::FUNC_READ_PAD, 1'b0, '0, '0, 1'b0, '0, 13'd100);
        send_word(pga_pkg::FUNC_READ_LAYER, 1'b0, 5'd31, '0, 1'b0, '0, '0);
        send_word(pga_pkg::FUNC_READ_LAYER, 1'b0, 5'd5, '0, 1'b0, '0, '0);
        send_word(pga_pkg::FUNC_READ_LAYER, 1'b0, 5'd10, '0, 1'b0, '0, '0);
    endtask

    // An event without a track closes counting until the next track event
    task automatic test_untracked_event();
        send_word(pga_pkg::FUNC_EVENT, 1'b0, '0, '0, 1'b0, '0, '0);
        send_word(pga_pkg::FUNC_CLUSTER, 1'b0, '0, '0, 1'b0, 16'h0100, '0);
        send_word(pga_pkg::FUNC_READ_PAD, 1'b0, '0, '0, 1'b0, '0, '0);
        send_word(pga_pkg::FUNC_READ_LAYER, 1'b0, '0, '0, 1'b0, '0, '0);
    endtask

    // Event sequences with random clusters and reads, plus some noise words
    task automatic test_random_traffic(input int pct, input int target);
        int                          goal;
        int                          nclu;
        int                          pick;
        logic [pga_pkg::LAYER_W-1:0] lyr;
        logic [pga_pkg::ROW_W-1:0]   rw;
        idle_pct = pct;
        goal     = words_sent + target;
        while (words_sent < goal) begin
            if ($urandom_range(99) < 10) begin
                send_word(2'($urandom), 1'($urandom), pga_pkg::LAYER_W'($urandom),
                          pga_pkg::ROW_W'($urandom), 1'($urandom),
                          pga_pkg::DEP_W'($urandom), pga_pkg::PIDX_W'($urandom));
            end else begin
                send_word(pga_pkg::FUNC_EVENT, $urandom_range(99) < 85,
                          pga_pkg::LAYER_W'($urandom), pga_pkg::ROW_W'($urandom),
                          1'($urandom), pga_pkg::DEP_W'($urandom),
                          pga_pkg::PIDX_W'($urandom));
                nclu = $urandom_range(1, 8);
                for (int c = 0; c < nclu; c++) begin
                    if ($urandom_range(99) < 20) begin
                        send_random_read();
                    end else begin
                        lyr  = pga_pkg::LAYER_W'($urandom_range(pga_pkg::HW_LAYERS - 1));
                        pick = $urandom_range(99);
                        if (pick < 50)
                            rw = pga_pkg::ROW_W'($urandom_range(7));
                        else if (pick < 85)
                            rw = pga_pkg::ROW_W'($urandom_range(pads_per_layer[lyr] - 1));
                        else
                            rw = pga_pkg::ROW_W'($urandom_range(255));
                        send_word(pga_pkg::FUNC_CLUSTER, 1'($urandom), lyr, rw,
                                  $urandom_range(99) < 10, pga_pkg::DEP_W'($urandom),
                                  pga_pkg::PIDX_W'($urandom));
                    end
                end
                send_random_read();
            end
        end
    endtask

    initial begin
        init_mirror();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_cleared_readback();
        test_cluster_cases();
        test_untracked_event();
        test_random_traffic(0, 275);
        test_random_traffic(64, 275);
        test_random_traffic(7, 275);
        @(posedge i_clk);
        start <= 1'b0;
        // drain pending reads, then let the pipeline settle
        while (readout_q.size() != 0) @(posedge i_clk);
        repeat (READ_LATENCY + 6) @(posedge i_clk);
        $display("covered %0d words (%0d with effect), %0d read results checked",
                 words_sent, words_counted, reads_checked);
        $display("idle mixes 0/64/7 percent, %0d mismatches", mismatches);
        if (mismatches == 0 && readout_q.size() == 0) begin
            $display("pad_gain_accumulator regression: pass");
        end else begin
            $display("pad_gain_accumulator regression: fail");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout with %0d reads pending", readout_q.size());
        $display("pad_gain_accumulator regression: fail");
        $finish;
    end

endmodule
